// ----- hdl/rgbhsl_pkg.sv -----
// Shared widths, hue constants and stage payload types for the RGB to HSL converter.
package rgbhsl_pkg;

    // Field widths.
    localparam int CH_W    = 8;
    localparam int HUE_W   = 13;
    localparam int FRAC_W  = 16;

    // Divider geometry: an 8-bit divisor, a 16-bit quotient, so a 24-bit dividend.
    localparam int DIV_DEN_W = CH_W;
    localparam int DIV_QUO_W = FRAC_W;
    localparam int DIV_NUM_W = DIV_DEN_W + DIV_QUO_W;

    // Register stages ahead of the output register: two front stages plus the divider.
    localparam int PIPE_STAGES = 2 + DIV_QUO_W;

    // Hue bases in sixteenths of a degree.
    localparam logic [HUE_W-1:0] HUE_BASE_RED      = 13'd0;
    localparam logic [HUE_W-1:0] HUE_BASE_RED_WRAP = 13'd5760;
    localparam logic [HUE_W-1:0] HUE_BASE_GREEN    = 13'd1920;
    localparam logic [HUE_W-1:0] HUE_BASE_BLUE     = 13'd3840;
    localparam logic [HUE_W-1:0] HUE_FULL_TURN     = 13'd5760;

    // First front stage: extremes, hue sector and the hue numerator difference.
    typedef struct packed {
        logic [CH_W-1:0]  mx;
        logic [CH_W-1:0]  mn;
        logic [CH_W-1:0]  num;
        logic             pos;
        logic [HUE_W-1:0] base;
        logic [CH_W-1:0]  alpha;
    } stage_a_t;

    // Values that ride alongside the dividers.
    typedef struct packed {
        logic [HUE_W-1:0]  hue_base;
        logic              hue_pos;
        logic              gray;
        logic [FRAC_W-1:0] light;
        logic [CH_W-1:0]   alpha;
    } side_t;

    // Second front stage: divider operands plus the side data.
    typedef struct packed {
        logic [DIV_NUM_W-1:0] sat_num;
        logic [DIV_DEN_W-1:0] sat_den;
        logic [DIV_NUM_W-1:0] hue_num;
        logic [DIV_DEN_W-1:0] hue_den;
        side_t                side;
    } front_t;

    // One finished result beat.
    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [FRAC_W-1:0] sat;
        logic [FRAC_W-1:0] light;
        logic [CH_W-1:0]   alpha;
    } result_t;

endpackage

// ----- hdl/rgbhsl_front.sv -----
// Two front pipeline stages: extremes and hue sector, then divider operands and lightness.
module rgbhsl_front (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [rgbhsl_pkg::CH_W-1:0] red,
    input  logic [rgbhsl_pkg::CH_W-1:0] green,
    input  logic [rgbhsl_pkg::CH_W-1:0] blue,
    input  logic [rgbhsl_pkg::CH_W-1:0] alpha,
    output rgbhsl_pkg::front_t          front_out
);
    import rgbhsl_pkg::*;

    stage_a_t stage_a_reg, stage_a_next;
    front_t   front_reg, front_next;

    logic [CH_W-1:0]      d;
    logic [CH_W:0]        sum;
    logic [CH_W:0]        den_hi;
    logic [2*CH_W:0]      light_full;
    logic [CH_W+9:0]      scaled;
    logic                 gray;

    // Stage A: find max and min, and pick the hue sector in the order red, green, blue.
    always_comb begin
        stage_a_next       = '0;
        stage_a_next.alpha = alpha;
        stage_a_next.mx    = red;
        stage_a_next.mn    = red;
        if (green > stage_a_next.mx) stage_a_next.mx = green;
        if (blue > stage_a_next.mx) stage_a_next.mx = blue;
        if (green < stage_a_next.mn) stage_a_next.mn = green;
        if (blue < stage_a_next.mn) stage_a_next.mn = blue;
        if (red >= green && red >= blue) begin
            stage_a_next.pos  = (green >= blue);
            stage_a_next.num  = (green >= blue) ? green - blue : blue - green;
            stage_a_next.base = (green >= blue) ? HUE_BASE_RED : HUE_BASE_RED_WRAP;
        end else if (green >= blue) begin
            stage_a_next.pos  = (blue >= red);
            stage_a_next.num  = (blue >= red) ? blue - red : red - blue;
            stage_a_next.base = HUE_BASE_GREEN;
        end else begin
            stage_a_next.pos  = (red >= green);
            stage_a_next.num  = (red >= green) ? red - green : green - red;
            stage_a_next.base = HUE_BASE_BLUE;
        end
    end

    // Stage B: spread, sum, lightness and the two dividends and divisors.
    always_comb begin
        d          = stage_a_reg.mx - stage_a_reg.mn;
        sum        = {1'b0, stage_a_reg.mx} + {1'b0, stage_a_reg.mn};
        gray       = (d == '0);
        den_hi     = 9'd510 - sum;
        light_full = {sum, 8'b0} + {8'b0, sum};
        // 960 * num as (num << 10) - (num << 6).
        scaled     = {stage_a_reg.num, 10'b0} - {4'b0, stage_a_reg.num, 6'b0};

        front_next                = '0;
        front_next.side.hue_base  = stage_a_reg.base;
        front_next.side.hue_pos   = stage_a_reg.pos;
        front_next.side.gray      = gray;
        front_next.side.light     = light_full[2*CH_W:1];
        front_next.side.alpha     = stage_a_reg.alpha;
        // 65535 * d as (d << 16) - d.
        front_next.sat_num        = {d, 16'b0} - {16'b0, d};
        if (gray) begin
            front_next.sat_den = 8'd1;
        end else if (sum < 9'd255) begin
            front_next.sat_den = sum[CH_W-1:0];
        end else begin
            front_next.sat_den = den_hi[CH_W-1:0];
        end
        // A falling hue is floored by taking the ceiling of the subtracted part.
        if (stage_a_reg.pos) begin
            front_next.hue_num = {6'b0, scaled};
        end else begin
            front_next.hue_num = {6'b0, scaled + {10'b0, d} - 18'd1};
        end
        front_next.hue_den = gray ? 8'd1 : d;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_a_reg <= stage_a_next;
            front_reg   <= front_next;
        end
    end

    assign front_out = front_reg;

endmodule

// ----- hdl/rgbhsl_div.sv -----
// Pipelined restoring divider: one quotient bit per register stage.
module rgbhsl_div (
    input  logic                             aclk,
    input  logic                             en,
    input  logic [rgbhsl_pkg::DIV_NUM_W-1:0] num_in,
    input  logic [rgbhsl_pkg::DIV_DEN_W-1:0] den_in,
    output logic [rgbhsl_pkg::DIV_QUO_W-1:0] quo_out
);
    import rgbhsl_pkg::*;

    // Upper bits hold the partial remainder, lower bits shift dividend out and quotient in.
    logic [DIV_NUM_W-1:0] work_reg [DIV_QUO_W];
    logic [DIV_DEN_W-1:0] den_reg  [DIV_QUO_W];

    for (genvar k = 0; k < DIV_QUO_W; k++) begin : g_step
        logic [DIV_NUM_W-1:0] work_in;
        logic [DIV_DEN_W-1:0] den_cur;
        logic [DIV_DEN_W:0]   trial;
        logic [DIV_DEN_W:0]   diff;
        logic [DIV_NUM_W-1:0] work_next;

        if (k == 0) begin : g_first
            assign work_in = num_in;
            assign den_cur = den_in;
        end else begin : g_rest
            assign work_in = work_reg[k-1];
            assign den_cur = den_reg[k-1];
        end

        // Bring down the next dividend bit and subtract when it fits.
        assign trial = work_in[DIV_NUM_W-1 -: DIV_DEN_W+1];
        assign diff  = trial - {1'b0, den_cur};

        always_comb begin
            if (trial >= {1'b0, den_cur}) begin
                work_next = {diff[DIV_DEN_W-1:0], work_in[DIV_QUO_W-2:0], 1'b1};
            end else begin
                work_next = {work_in[DIV_NUM_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                work_reg[k] <= work_next;
                den_reg[k]  <= den_cur;
            end
        end
    end

    assign quo_out = work_reg[DIV_QUO_W-1][DIV_QUO_W-1:0];

endmodule

// ----- hdl/rgbhsl_out.sv -----
// Hue finish, gray override, output register and skid buffer.
module rgbhsl_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pipe_valid,
    input  logic [rgbhsl_pkg::FRAC_W-1:0] hue_quo,
    input  logic [rgbhsl_pkg::FRAC_W-1:0] sat_quo,
    input  rgbhsl_pkg::side_t             side,
    output logic                          pipe_en,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rgbhsl_pkg::HUE_W-1:0]  m_hue_out,
    output logic [rgbhsl_pkg::FRAC_W-1:0] m_saturation_out,
    output logic [rgbhsl_pkg::FRAC_W-1:0] m_lightness_out,
    output logic [rgbhsl_pkg::CH_W-1:0]   m_alpha_out
);
    import rgbhsl_pkg::*;

    result_t res_next;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;

    // Add or subtract the hue offset from its sector base; a gray pixel forces zero.
    always_comb begin
        res_next.light = side.light;
        res_next.alpha = side.alpha;
        if (side.gray) begin
            res_next.hue = '0;
            res_next.sat = '0;
        end else begin
            res_next.hue = side.hue_pos ? side.hue_base + hue_quo[HUE_W-1:0]
                                        : side.hue_base - hue_quo[HUE_W-1:0];
            res_next.sat = sat_quo;
        end
    end

    // The pipeline advances whenever the skid slot is free.
    assign pipe_en = ~skid_valid_reg;

    // Control: output beat and skid beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (out_valid_reg && !m_ready) begin
            if (pipe_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end else begin
            out_valid_reg <= pipe_valid;
        end
    end

    // Payload: refill the output from the skid slot or straight from the pipeline.
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_reg <= skid_reg;
            end
        end else if (out_valid_reg && !m_ready) begin
            if (pipe_valid) begin
                skid_reg <= res_next;
            end
        end else if (pipe_valid) begin
            out_reg <= res_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_hue_out        = out_reg.hue;
    assign m_saturation_out = out_reg.sat;
    assign m_lightness_out  = out_reg.light;
    assign m_alpha_out      = out_reg.alpha;

    // The skid slot only holds a beat while the output register is also full.
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat held without an output beat");

    // A beat goes to the skid slot only when the output was stalled.
    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("skid slot filled while the output was free");

    // Hue stays inside one turn.
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.hue < HUE_FULL_TURN))
        else $error("hue out of range");

endmodule

// ----- hdl/rgb_to_hsl_pixel_convert.sv -----
// Top level of the RGBA to HSLA pixel converter.
//
//  Channel  Ports                                           Direction
//  s_       s_valid s_ready s_red_in s_green_in s_blue_in   in, one RGBA pixel per beat
//           s_alpha_in
//  m_       m_valid m_ready m_hue_out m_saturation_out      out, one HSLA result per beat
//           m_lightness_out m_alpha_out
//
// One pixel enters per cycle while s_ready is high; an accepted beat passes through the
// two front stages, a 16-stage divider producing one quotient bit per stage, and the
// output register before its result is on the m_ ports.
// Reset is synchronous and only clears the valid bits.
// When m_ready is low with the output register full, the next beat is caught in a skid
// register and the whole pipeline then holds, with s_ready low, until that beat drains.
module rgb_to_hsl_pixel_convert (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rgbhsl_pkg::CH_W-1:0]   s_red_in,
    input  logic [rgbhsl_pkg::CH_W-1:0]   s_green_in,
    input  logic [rgbhsl_pkg::CH_W-1:0]   s_blue_in,
    input  logic [rgbhsl_pkg::CH_W-1:0]   s_alpha_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rgbhsl_pkg::HUE_W-1:0]  m_hue_out,
    output logic [rgbhsl_pkg::FRAC_W-1:0] m_saturation_out,
    output logic [rgbhsl_pkg::FRAC_W-1:0] m_lightness_out,
    output logic [rgbhsl_pkg::CH_W-1:0]   m_alpha_out
);
    import rgbhsl_pkg::*;

    logic              pipe_en;
    front_t            front;
    logic [FRAC_W-1:0] hue_quo;
    logic [FRAC_W-1:0] sat_quo;
    logic              vld_reg  [PIPE_STAGES];
    side_t             side_reg [DIV_QUO_W];

    assign s_ready = pipe_en;

    rgbhsl_front u_front (
        .aclk      (aclk),
        .en        (pipe_en),
        .red       (s_red_in),
        .green     (s_green_in),
        .blue      (s_blue_in),
        .alpha     (s_alpha_in),
        .front_out (front)
    );

    rgbhsl_div u_div_sat (
        .aclk    (aclk),
        .en      (pipe_en),
        .num_in  (front.sat_num),
        .den_in  (front.sat_den),
        .quo_out (sat_quo)
    );

    rgbhsl_div u_div_hue (
        .aclk    (aclk),
        .en      (pipe_en),
        .num_in  (front.hue_num),
        .den_in  (front.hue_den),
        .quo_out (hue_quo)
    );

    // Valid bits shadow every pipeline stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_STAGES; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (pipe_en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < PIPE_STAGES; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Side data runs beside the divider stages.
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            side_reg[0] <= front.side;
            for (int i = 1; i < DIV_QUO_W; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    rgbhsl_out u_out (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .pipe_valid       (vld_reg[PIPE_STAGES-1]),
        .hue_quo          (hue_quo),
        .sat_quo          (sat_quo),
        .side             (side_reg[DIV_QUO_W-1]),
        .pipe_en          (pipe_en),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hue_out        (m_hue_out),
        .m_saturation_out (m_saturation_out),
        .m_lightness_out  (m_lightness_out),
        .m_alpha_out      (m_alpha_out)
    );

endmodule
